// ===== src/vlss_pkg.sv =====
`timescale 1ns / 1ps
package vlss_pkg;

  localparam int SlotCount = 16;
  localparam int SlotW = $clog2(SlotCount);
  localparam int CntW = $clog2(SlotCount + 1);
  localparam int ProdW = 16 + CntW;

  typedef enum logic [2:0] {
    MODE_SINGLE = 3'd0,
    MODE_LAYERS = 3'd1,
    MODE_XFADE  = 3'd2,
    MODE_ROUND  = 3'd3,
    MODE_RANDOM = 3'd4,
    MODE_STACK  = 3'd5,
    MODE_CHORD  = 3'd6,
    MODE_NONE   = 3'd7
  } trig_mode_t;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_CLEAR_ALL = 2'd2,
    REQ_TRIGGER = 2'd3
  } req_t;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_FLOOR = 2'd1;
  localparam logic [1:0] CFG_CEIL  = 2'd2;
  localparam logic [1:0] CFG_SEED  = 2'd3;

  localparam logic [15:0] SeedReset = 16'd44257;
  localparam logic [15:0] LfsrMask  = 16'hB400;

  typedef struct packed {
    logic       active;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [3:0] prio;
    logic [5:0] chord;
  } slot_t;

  // Divider handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic        start;
    logic [24:0] dividend;
    logic [7:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [24:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_MOD,
    ST_SCAN,
    ST_DIV,
    ST_EMIT,
    ST_OUT
  } state_t;

endpackage

// ===== src/vlss_divider.sv =====
`timescale 1ns / 1ps
module vlss_divider
  import vlss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [24:0] quo_r, quo_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [7:0]  dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [9:0]  trial;

  // One quotient bit per cycle, restoring division.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[24]} - {2'b00, dvs_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 5'd24;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[9]) begin
        rem_nxt = trial[8:0];
        quo_nxt = {quo_r[23:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[7:0], quo_r[24]};
        quo_nxt = {quo_r[23:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      cnt_nxt = cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without work");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !req.start && cnt_r != '0 |=> busy_r)
    else $error("divider stopped early");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r)
    else $error("divider did not start");
`endif

endmodule

// ===== src/velocity_layer_slot_selector.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// in_       input      in_valid / in_ready      request fields
// out_      output     out_valid / out_ready    one chosen slot per result
// cfg_      input      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Writes and clears finish in the cycle their request is accepted. A trigger
// counts the active slots in ST_COUNT, then scans the 16 slots in ST_SCAN.
// Round robin adds ST_MOD for the modulo; in single mode each active
// in-range slot with hi above lo holds the scan in ST_DIV for the divider.
// Each result passes through ST_EMIT and then waits in ST_OUT.
// Reset is synchronous; the table, settings, state and counters clear at once.
// The block takes no request while a trigger runs or a result waits.
module velocity_layer_slot_selector
  import vlss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [3:0]        in_slot_index,
  input  logic [7:0]        in_vel_low,
  input  logic [7:0]        in_vel_high,
  input  logic [3:0]        in_slot_priority,
  input  logic signed [5:0] in_chord_step,
  input  logic              in_slot_enable,
  input  logic [7:0]        in_trig_velocity,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_chosen_slot,
  output logic signed [5:0] out_chosen_chord_step,
  output logic [7:0]        out_used_velocity,
  output logic              out_last_of_run,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  slot_t                table_r [SlotCount];
  state_t               state_r, state_nxt;
  trig_mode_t           mode_r;
  logic [7:0]           floor_r, ceil_r, vel_r;
  logic [15:0]          rnd_r, rnd_nxt, rnd_step;
  logic [3:0]           rot_r, rot_nxt;
  logic [SlotW-1:0]     idx_r, idx_nxt;
  logic [CntW-1:0]      n_r, n_nxt, k_r, k_nxt, target_r, target_nxt;
  logic                 found_r, found_nxt, have_r, have_nxt;
  logic [SlotW-1:0]     best_r, best_nxt, first_r, first_nxt;
  logic [23:0]          best_score_r, best_score_nxt;
  logic [SlotCount-1:0] sel_r, sel_nxt, sel_rest;
  logic [SlotW-1:0]     low_idx;
  logic [3:0]           o_slot_r;
  logic [5:0]           o_chord_r;
  logic                 o_last_r;
  div_req_t             dreq;
  div_rsp_t             drsp;
  slot_t                cur;
  logic                 cur_in, cur_single;
  logic [8:0]           twice, sum, offs;
  logic [7:0]           width;
  logic [16:0]          p_val;
  logic [5:0]           prio3;
  logic [23:0]          score;
  logic [7:0]           vclamp;
  logic [ProdW-1:0]     rprod;
  logic                 accept_in, accept_cfg, scan_end;

  vlss_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_ready   = (state_r == ST_IDLE) && !out_valid;
  assign cfg_ready  = 1'b1;
  assign accept_in  = in_valid && in_ready;
  assign accept_cfg = cfg_valid && cfg_ready;
  assign out_valid  = (state_r == ST_OUT);
  assign out_chosen_slot       = o_slot_r;
  assign out_chosen_chord_step = o_chord_r;
  assign out_used_velocity     = vel_r;
  assign out_last_of_run       = o_last_r;

  // Current slot under the scan pointer and its single-mode score.
  always_comb begin
    cur        = table_r[idx_r];
    cur_in     = (vel_r >= cur.lo) && (vel_r <= cur.hi);
    cur_single = cur.active && cur_in && (cur.hi > cur.lo);
    width      = cur.hi - cur.lo;
    twice      = {vel_r, 1'b0};
    sum        = {1'b0, cur.lo} + {1'b0, cur.hi};
    offs       = (twice >= sum) ? twice - sum : sum - twice;
    p_val      = 17'h10000 - drsp.quotient[16:0];
    // The priority weight 196608 is three times 65536.
    prio3      = {2'b00, cur.prio} + {1'b0, cur.prio, 1'b0};
    score      = (24'(p_val) * 24'd105) + {2'b00, prio3, 16'h0000};
    vclamp     = (in_trig_velocity > ceil_r) ? ceil_r : in_trig_velocity;
    if (vclamp < floor_r) vclamp = floor_r;
  end

  // Random mode steps the register once per trigger with active slots.
  assign rnd_step = rnd_r[0] ? ((rnd_r >> 1) ^ LfsrMask) : (rnd_r >> 1);

  // Lowest selected slot is emitted next.
  always_comb begin
    low_idx = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (sel_r[i]) low_idx = SlotW'(i);
    end
    sel_rest = sel_r;
    sel_rest[low_idx] = 1'b0;
  end

  // Sequencer: count, reduce, scan, divide, emit.
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    target_nxt     = target_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_score_nxt = best_score_r;
    have_nxt       = have_r;
    first_nxt      = first_r;
    sel_nxt        = sel_r;
    rot_nxt        = rot_r;
    rnd_nxt        = rnd_r;
    rprod          = '0;
    scan_end       = 1'b0;
    dreq.start     = 1'b0;
    dreq.dividend  = {offs, 16'h0000};
    dreq.divisor   = width;
    unique case (state_r)
      ST_IDLE: begin
        if (accept_in && req_t'(in_req_type) == REQ_TRIGGER) begin
          state_nxt = ST_COUNT;
          idx_nxt   = '0;
          n_nxt     = '0;
        end
      end
      ST_COUNT: begin
        if (cur.active) n_nxt = n_r + CntW'(1);
        idx_nxt = idx_r + SlotW'(1);
        if (idx_r == SlotW'(SlotCount - 1)) begin
          k_nxt          = '0;
          found_nxt      = 1'b0;
          have_nxt       = 1'b0;
          sel_nxt        = '0;
          best_score_nxt = '0;
          target_nxt     = '0;
          if (n_nxt == '0 || mode_r == MODE_NONE) begin
            state_nxt = ST_IDLE;
          end else if (mode_r == MODE_ROUND) begin
            target_nxt = CntW'(rot_r);
            state_nxt  = ST_MOD;
          end else begin
            if (mode_r == MODE_RANDOM) begin
              rnd_nxt    = rnd_step;
              rprod      = ProdW'(rnd_step) * ProdW'(n_nxt);
              target_nxt = rprod[ProdW-1:16];
            end
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_MOD: begin
        // Rotation modulo the active count by repeated subtraction.
        if (target_r >= n_r) begin
          target_nxt = target_r - n_r;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // The first active slot is the fallback of single mode.
        if (cur.active && !have_r) begin
          have_nxt  = 1'b1;
          first_nxt = idx_r;
        end
        case (mode_r) inside
          MODE_SINGLE: begin
            if (cur_single) begin
              dreq.start = 1'b1;
              state_nxt  = ST_DIV;
            end
          end
          MODE_LAYERS: begin
            if (cur.active && cur_in) sel_nxt[idx_r] = 1'b1;
          end
          MODE_ROUND, MODE_RANDOM: begin
            if (cur.active) begin
              if (k_r == target_r) sel_nxt[idx_r] = 1'b1;
              k_nxt = k_r + CntW'(1);
            end
          end
          MODE_XFADE, MODE_STACK, MODE_CHORD: begin
            if (cur.active) sel_nxt[idx_r] = 1'b1;
          end
          default: ;
        endcase
        if (!dreq.start) begin
          idx_nxt  = idx_r + SlotW'(1);
          scan_end = (idx_r == SlotW'(SlotCount - 1));
        end
      end
      ST_DIV: begin
        if (drsp.done) begin
          if (!found_r || score > best_score_r) begin
            found_nxt      = 1'b1;
            best_nxt       = idx_r;
            best_score_nxt = score;
          end
          state_nxt = ST_SCAN;
          idx_nxt   = idx_r + SlotW'(1);
          scan_end  = (idx_r == SlotW'(SlotCount - 1));
        end
      end
      ST_EMIT: begin
        if (sel_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          sel_nxt   = sel_rest;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          if (o_last_r) begin
            state_nxt = ST_IDLE;
            if (mode_r == MODE_ROUND)
              rot_nxt = (target_r + CntW'(1) == n_r) ? 4'd0 : 4'(target_r + CntW'(1));
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // End of the scan: single mode selects the best or the fallback slot.
    if (scan_end) begin
      state_nxt = ST_EMIT;
      if (mode_r == MODE_SINGLE) begin
        sel_nxt = '0;
        sel_nxt[found_nxt ? best_nxt : first_nxt] = 1'b1;
      end
    end
    // Clearing the table or writing the mode resets the rotation.
    if (accept_in && req_t'(in_req_type) == REQ_CLEAR_ALL) rot_nxt = '0;
    if (accept_cfg && cfg_index == CFG_MODE) rot_nxt = '0;
    if (accept_cfg && cfg_index == CFG_SEED) rnd_nxt = cfg_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      mode_r   <= MODE_SINGLE;
      floor_r  <= 8'd0;
      ceil_r   <= 8'd255;
      rnd_r    <= SeedReset;
      rot_r    <= '0;
      for (int i = 0; i < SlotCount; i++) table_r[i] <= '0;
      idx_r    <= '0;
      n_r      <= '0;
      k_r      <= '0;
      target_r <= '0;
      found_r  <= 1'b0;
      have_r   <= 1'b0;
      sel_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      n_r      <= n_nxt;
      k_r      <= k_nxt;
      target_r <= target_nxt;
      found_r  <= found_nxt;
      have_r   <= have_nxt;
      sel_r    <= sel_nxt;
      rot_r    <= rot_nxt;
      rnd_r    <= rnd_nxt;
      if (accept_in) begin
        unique case (req_t'(in_req_type))
          REQ_WRITE: begin
            table_r[in_slot_index].active <= in_slot_enable;
            table_r[in_slot_index].lo     <= in_vel_low;
            table_r[in_slot_index].hi     <= (in_vel_high < in_vel_low) ? in_vel_low
                                                                        : in_vel_high;
            table_r[in_slot_index].prio   <= in_slot_priority;
            table_r[in_slot_index].chord  <= in_chord_step;
          end
          REQ_CLEAR: table_r[in_slot_index] <= '0;
          REQ_CLEAR_ALL: begin
            for (int i = 0; i < SlotCount; i++) table_r[i] <= '0;
          end
          REQ_TRIGGER: vel_r <= vclamp;
          default: ;
        endcase
      end
      if (accept_cfg) begin
        unique case (cfg_index)
          CFG_MODE:  mode_r <= trig_mode_t'(cfg_data[2:0]);
          CFG_FLOOR: floor_r <= cfg_data[7:0];
          CFG_CEIL:  ceil_r <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
    best_r       <= best_nxt;
    best_score_r <= best_score_nxt;
    first_r      <= first_nxt;
    // Load the result register with the lowest remaining slot.
    if (state_r == ST_EMIT) begin
      o_slot_r  <= low_idx;
      o_chord_r <= table_r[low_idx].chord;
      o_last_r  <= (sel_rest == '0);
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_chosen_slot))
    else $error("result dropped");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ready)
    else $error("ready while busy");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> state_r == ST_DIV)
    else $error("divider result unused");
`endif

endmodule
